>>> design/lrgd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrgd_pkg
// Shared constants, codes, state type and control structs of the
// gradient-descent regression block.
// ----------------------------------------------------------------------------
package lrgd_pkg;

    localparam int LRGD_MAX_ROWS = 256;
    localparam int LRGD_MAX_COLS = 16;

    // field and register widths
    localparam int KIND_W   = 2;
    localparam int ROW_W    = 8;
    localparam int COL_W    = 4;
    localparam int VAL_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 17;
    localparam int LR_W     = 17;
    localparam int STEP_W   = 16;
    localparam int ROWS_W   = 9;
    localparam int COLS_W   = 5;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_FEATURE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TARGET  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RUN     = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS_IN_USE = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RES_RD,
        ST_RES_MUL,
        ST_RES_ACC,
        ST_RES_WR,
        ST_GR_RD,
        ST_GR_MUL,
        ST_GR_ACC,
        ST_DIV_LD,
        ST_DIV,
        ST_MAG,
        ST_SCL_HI,
        ST_SCL_LO,
        ST_UPD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic ld_feat;
        logic ld_tgt;
        logic start;
        logic res_rd;
        logic gr_rd;
        logic mul_res;
        logic mul_gr;
        logic res_acc;
        logic res_wr;
        logic gr_acc;
        logic div_start;
        logic div_step;
        logic mag;
        logic scl_hi;
        logic scl_lo;
        logic upd;
        logic out_adv;
    } t_cmd;

    typedef struct packed {
        logic last_i;
        logic last_j;
        logic div_last;
        logic step_last;
        logic limit_zero;
    } t_stat;

    // clamp a 64-bit value to 32 signed bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> design/lrgd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrgd_in_if
// Input channel: load and run items.
// ----------------------------------------------------------------------------
interface lrgd_in_if
    import lrgd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, kind, row, col, value, input ready);
    modport sink   (input valid, kind, row, col, value, output ready);
endinterface

>>> design/lrgd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrgd_out_if
// Output channel: fitted coefficients, one item per column.
// ----------------------------------------------------------------------------
interface lrgd_out_if
    import lrgd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [COL_W-1:0]  coef_index;
    logic signed [VAL_W-1:0] coef_value;
    logic              last;

    modport source (output valid, coef_index, coef_value, last, input ready);
    modport sink   (input valid, coef_index, coef_value, last, output ready);
endinterface

>>> design/lrgd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrgd_ctrl
// Sequencer: walks residual pass, gradient pass, divide, scale and update.
// ----------------------------------------------------------------------------
module lrgd_ctrl
    import lrgd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [KIND_W-1:0] i_in_kind,
    input  logic              i_out_ready,
    input  t_stat             i_stat,
    output t_cmd              o_cmd,
    output logic              o_in_ready,
    output logic              o_out_valid
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_in_kind == KIND_RUN) begin
                    n_state = i_stat.limit_zero ? ST_OUT : ST_RES_RD;
                end
            end
            ST_RES_RD:  n_state = ST_RES_MUL;
            ST_RES_MUL: n_state = ST_RES_ACC;
            ST_RES_ACC: n_state = i_stat.last_j ? ST_RES_WR : ST_RES_RD;
            ST_RES_WR:  n_state = i_stat.last_i ? ST_GR_RD : ST_RES_RD;
            ST_GR_RD:   n_state = ST_GR_MUL;
            ST_GR_MUL:  n_state = ST_GR_ACC;
            ST_GR_ACC:  n_state = i_stat.last_i ? ST_DIV_LD : ST_GR_RD;
            ST_DIV_LD:  n_state = ST_DIV;
            ST_DIV:     n_state = i_stat.div_last ? ST_MAG : ST_DIV;
            ST_MAG:     n_state = ST_SCL_HI;
            ST_SCL_HI:  n_state = ST_SCL_LO;
            ST_SCL_LO:  n_state = ST_UPD;
            ST_UPD: begin
                if (!i_stat.last_j) begin
                    n_state = ST_GR_RD;
                end else if (i_stat.step_last) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_RES_RD;
                end
            end
            ST_OUT: begin
                if (i_out_ready && i_stat.last_j) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        logic accept;
        accept      = i_in_valid && (r_state == ST_IDLE);
        o_cmd       = '0;
        o_in_ready  = (r_state == ST_IDLE);
        o_out_valid = (r_state == ST_OUT);
        o_cmd.ld_feat = accept && (i_in_kind == KIND_FEATURE);
        o_cmd.ld_tgt  = accept && (i_in_kind == KIND_TARGET);
        o_cmd.start   = accept && (i_in_kind == KIND_RUN);
        case (r_state)
            ST_RES_RD:  o_cmd.res_rd    = 1'b1;
            ST_RES_MUL: o_cmd.mul_res   = 1'b1;
            ST_RES_ACC: o_cmd.res_acc   = 1'b1;
            ST_RES_WR:  o_cmd.res_wr    = 1'b1;
            ST_GR_RD:   o_cmd.gr_rd     = 1'b1;
            ST_GR_MUL:  o_cmd.mul_gr    = 1'b1;
            ST_GR_ACC:  o_cmd.gr_acc    = 1'b1;
            ST_DIV_LD:  o_cmd.div_start = 1'b1;
            ST_DIV:     o_cmd.div_step  = 1'b1;
            ST_MAG:     o_cmd.mag       = 1'b1;
            ST_SCL_HI:  o_cmd.scl_hi    = 1'b1;
            ST_SCL_LO:  o_cmd.scl_lo    = 1'b1;
            ST_UPD:     o_cmd.upd       = 1'b1;
            ST_OUT:     o_cmd.out_adv   = i_out_ready;
            default: ;
        endcase
    end

endmodule

>>> design/lrgd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrgd_dp
// Datapath: stores, counters, multiply-accumulate, serial divider,
// step scaling and coefficient registers.
// ----------------------------------------------------------------------------
module lrgd_dp
    import lrgd_pkg::*;
#(
    parameter int MAX_ROWS = LRGD_MAX_ROWS,
    parameter int MAX_COLS = LRGD_MAX_COLS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [ROW_W-1:0]     i_row,
    input  logic [COL_W-1:0]     i_col,
    input  logic signed [VAL_W-1:0] i_value,
    output logic [COL_W-1:0]     o_coef_index,
    output logic signed [VAL_W-1:0] o_coef_value
);

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;
    localparam int PW = LR_W + 32;

    // configuration
    logic [LR_W-1:0]   r_lr;
    logic [STEP_W-1:0] r_limit;
    logic [ROWS_W-1:0] r_rows;
    logic [COLS_W-1:0] r_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr    <= LR_W'(655);
            r_limit <= STEP_W'(1000);
            r_rows  <= ROWS_W'(256);
            r_cols  <= COLS_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LEARNING_RATE:  r_lr    <= i_cfg_data[LR_W-1:0];
                CFG_STEP_LIMIT:     r_limit <= i_cfg_data[STEP_W-1:0];
                CFG_ROWS_IN_USE:    r_rows  <= i_cfg_data[ROWS_W-1:0];
                CFG_COLUMNS_IN_USE: r_cols  <= i_cfg_data[COLS_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped counts
    logic [ROWS_W-1:0] w_m;
    logic [COLS_W-1:0] w_n;
    always_comb begin
        if (r_rows == '0) begin
            w_m = ROWS_W'(1);
        end else if (32'(r_rows) > MAX_ROWS) begin
            w_m = ROWS_W'(MAX_ROWS);
        end else begin
            w_m = r_rows;
        end
        if (r_cols == '0) begin
            w_n = COLS_W'(1);
        end else if (32'(r_cols) > MAX_COLS) begin
            w_n = COLS_W'(MAX_COLS);
        end else begin
            w_n = r_cols;
        end
    end

    // counters
    logic [ROW_W-1:0]  r_i;
    logic [COL_W-1:0]  r_j;
    logic [STEP_W-1:0] r_step;
    logic [5:0]        r_dcnt;

    assign o_stat.last_i     = ({1'b0, r_i} == (w_m - ROWS_W'(1)));
    assign o_stat.last_j     = ({1'b0, r_j} == (w_n - COLS_W'(1)));
    assign o_stat.div_last   = (r_dcnt == 6'd63);
    assign o_stat.step_last  = ((17'(r_step) + 17'd1) == 17'(r_limit));
    assign o_stat.limit_zero = (r_limit == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i    <= '0;
            r_j    <= '0;
            r_step <= '0;
            r_dcnt <= '0;
        end else begin
            if (i_cmd.start) begin
                r_i    <= '0;
                r_j    <= '0;
                r_step <= '0;
            end
            if (i_cmd.res_acc || i_cmd.out_adv) begin
                r_j <= o_stat.last_j ? '0 : r_j + COL_W'(1);
            end
            if (i_cmd.res_wr || i_cmd.gr_acc) begin
                r_i <= o_stat.last_i ? '0 : r_i + ROW_W'(1);
            end
            if (i_cmd.upd) begin
                r_j <= o_stat.last_j ? '0 : r_j + COL_W'(1);
                if (o_stat.last_j) begin
                    r_step <= r_step + STEP_W'(1);
                end
            end
            if (i_cmd.div_start) begin
                r_dcnt <= '0;
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt + 6'd1;
            end
        end
    end

    // stores
    logic signed [31:0] r_feat_mem [MAX_ROWS * MAX_COLS];
    logic signed [31:0] r_tgt_mem  [MAX_ROWS];
    logic signed [31:0] r_res_mem  [MAX_ROWS];
    logic signed [31:0] r_feat_q, r_tgt_q, r_resid_q;
    logic [AW-1:0]      w_ld_addr, w_rd_addr;
    logic signed [63:0] r_acc;
    logic signed [31:0] w_resid;

    assign w_ld_addr = AW'(32'(i_row) * MAX_COLS + 32'(i_col));
    assign w_rd_addr = AW'(32'(r_i) * MAX_COLS + 32'(r_j));
    assign w_resid   = sat32(r_acc - 64'(r_tgt_q));

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_feat && 32'(i_row) < MAX_ROWS && 32'(i_col) < MAX_COLS) begin
            r_feat_mem[w_ld_addr] <= i_value;
        end
        if (i_cmd.ld_tgt && 32'(i_row) < MAX_ROWS) begin
            r_tgt_mem[RW'(i_row)] <= i_value;
        end
        if (i_cmd.res_wr) begin
            r_res_mem[RW'(r_i)] <= w_resid;
        end
        if (i_cmd.res_rd || i_cmd.gr_rd) begin
            r_feat_q <= r_feat_mem[w_rd_addr];
        end
        if (i_cmd.res_rd) begin
            r_tgt_q <= r_tgt_mem[RW'(r_i)];
        end
        if (i_cmd.gr_rd) begin
            r_resid_q <= r_res_mem[RW'(r_i)];
        end
    end

    // coefficients
    logic signed [31:0] r_theta [MAX_COLS];
    logic signed [31:0] w_theta_j;
    assign w_theta_j = r_theta[CW'(r_j)];

    // multiply, then accumulate floor(p / 2^16)
    logic signed [31:0] w_op_b;
    logic signed [63:0] w_prod, r_prod;
    assign w_op_b = i_cmd.mul_gr ? r_resid_q : w_theta_j;
    assign w_prod = r_feat_q * w_op_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_res || i_cmd.mul_gr) begin
            r_prod <= w_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.start || i_cmd.res_wr || i_cmd.div_start) begin
            r_acc <= '0;
        end else if (i_cmd.res_acc || i_cmd.gr_acc) begin
            r_acc <= r_acc + (r_prod >>> 16);
        end
    end

    // restoring divider, magnitude of gradient by row count, one bit a cycle
    logic [63:0]       r_dvd;
    logic [ROWS_W-1:0] r_rem;
    logic              r_neg;
    logic [ROWS_W:0]   w_trial;
    logic              w_qbit;
    assign w_trial = {r_rem, r_dvd[63]};
    assign w_qbit  = (w_trial >= {1'b0, w_m});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dvd <= r_acc[63] ? 64'(-r_acc) : 64'(r_acc);
            r_neg <= r_acc[63];
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[62:0], w_qbit};
            r_rem <= w_qbit ? ROWS_W'(w_trial - {1'b0, w_m}) : w_trial[ROWS_W-1:0];
        end else if (i_cmd.mag) begin
            // floor division: round the magnitude up for negative gradients
            r_dvd <= r_dvd + 64'(r_neg && (r_rem != '0));
        end
    end

    // learning rate times magnitude, in two 17x32 halves
    logic [31:0]   w_half;
    logic [PW-1:0] w_sprod, r_ph, r_pl;
    assign w_half  = i_cmd.scl_hi ? r_dvd[63:32] : r_dvd[31:0];
    assign w_sprod = PW'(r_lr) * PW'(w_half);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scl_hi) begin
            r_ph <= w_sprod;
        end
        if (i_cmd.scl_lo) begin
            r_pl <= w_sprod;
        end
    end

    // coefficient update; a huge step is capped, it saturates anyway
    logic [63:0]        w_q;
    logic               w_frac;
    logic signed [63:0] w_stepv, w_th64;
    always_comb begin
        if (r_ph >= PW'(64'd16777216)) begin
            w_q    = 64'd1 << 40;
            w_frac = 1'b0;
        end else begin
            w_q    = (64'(r_ph) << 16) + 64'(r_pl >> 16);
            w_frac = (r_pl[15:0] != '0);
        end
        w_stepv = r_neg ? -$signed(w_q + 64'(w_frac)) : $signed(w_q);
        w_th64  = 64'(w_theta_j);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.start) begin
            for (int k = 0; k < MAX_COLS; k++) begin
                r_theta[k] <= '0;
            end
        end else if (i_cmd.upd) begin
            r_theta[CW'(r_j)] <= sat32(w_th64 - w_stepv);
        end
    end

    assign o_coef_index = r_j;
    assign o_coef_value = w_theta_j;

endmodule

>>> design/linear_regression_gradient_descent.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_regression_gradient_descent
// Batch gradient-descent linear regression in Q16.16 fixed point.
// Load items: one per cycle while idle. Run item (m rows, n cols, S steps):
//   S steps, each a residual pass and a gradient pass through the multiplier
//   shared by both passes, one store read per product and a serial divider;
//   then n coefficient items, one per cycle while accepted.
// Synchronous active-low reset; stores hold no value until written.
// ----------------------------------------------------------------------------
module linear_regression_gradient_descent
    import lrgd_pkg::*;
#(
    parameter int MAX_ROWS = LRGD_MAX_ROWS,
    parameter int MAX_COLS = LRGD_MAX_COLS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lrgd_in_if.sink              i_item,
    lrgd_out_if.source           o_coef,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer
    lrgd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_kind   (i_item.kind),
        .i_out_ready (o_coef.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_coef.valid)
    );

    // datapath
    lrgd_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_row        (i_item.row),
        .i_col        (i_item.col),
        .i_value      (i_item.value),
        .o_coef_index (o_coef.coef_index),
        .o_coef_value (o_coef.coef_value)
    );

    assign o_coef.last = w_stat.last_j;

endmodule

>>> design/lrgd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrgd_checker
// Port-level checks of the coefficient stream and busy behavior.
// ----------------------------------------------------------------------------
module lrgd_checker
    import lrgd_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [COL_W-1:0] i_out_index,
    input logic             i_out_last
);

    // a waiting coefficient holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_index))
        else $error("coefficient item dropped while stalled");

    // no item taken while results are pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while coefficients pending");

    // indexes climb by one within a run
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=>
            i_out_valid && i_out_index == $past(i_out_index) + COL_W'(1))
        else $error("coefficient index sequence broken");

    // run ends after the last coefficient
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_last |=> !i_out_valid && i_in_ready)
        else $error("stream continued after last coefficient");

endmodule

bind linear_regression_gradient_descent lrgd_checker u_lrgd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_coef.valid),
    .i_out_ready (o_coef.ready),
    .i_out_index (o_coef.coef_index),
    .i_out_last  (o_coef.last)
);
